[rtl/mwo_pkg.sv]
`timescale 1ns / 1ps

package mwo_pkg;

  // Waveform select codes; codes above WAVE_SILENT also give silence
  typedef enum logic [2:0] {
    WAVE_PULSE  = 3'd0,
    WAVE_SAW    = 3'd1,
    WAVE_TRI    = 3'd2,
    WAVE_SINE   = 3'd3,
    WAVE_NOISE  = 3'd4,
    WAVE_SILENT = 3'd5
  } wave_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_RUNNING = 8'd1;

  // Queue between front and back (depth must be a power of two)
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // One queued tick: phase step and whether the oscillator runs on it
  typedef struct packed {
    logic [30:0] inc;
    logic        run;
  } mwo_item_t;

  // Noise generator constants
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  // Sine table
  localparam int SINE_DEPTH = 256;
  localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint Q30_ONE     = 64'sd1073741824;

  typedef logic signed [15:0] sine_rom_t [SINE_DEPTH];

  // sin(pi/2 * f), f in Q30 over [0,1]; six truncated Taylor terms, result Q30
  function automatic longint quarter_sine(longint f);
    longint z;
    longint z2;
    longint term;
    longint sum;
    z    = (f * HALF_PI_Q30) / Q30_ONE;
    z2   = (z * z) / Q30_ONE;
    term = z;
    sum  = z;
    term = ((term * z2) / Q30_ONE) / 6;
    sum  = sum - term;
    term = ((term * z2) / Q30_ONE) / 20;
    sum  = sum + term;
    term = ((term * z2) / Q30_ONE) / 42;
    sum  = sum - term;
    term = ((term * z2) / Q30_ONE) / 72;
    sum  = sum + term;
    term = ((term * z2) / Q30_ONE) / 110;
    sum  = sum - term;
    if (sum < 0) begin
      sum = 0;
    end
    return sum;
  endfunction

  // Full-wave table in Q1.15, built from the quarter wave at elaboration
  function automatic sine_rom_t build_sine();
    sine_rom_t rom;
    longint    pos;
    longint    quad;
    longint    rem;
    longint    num;
    longint    f;
    longint    s;
    longint    q15;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      pos  = longint'(i) * 4;
      quad = pos / SINE_DEPTH;
      rem  = pos % SINE_DEPTH;
      num  = quad[0] ? (SINE_DEPTH - rem) : rem;
      f    = (num << 30) / SINE_DEPTH;
      s    = quarter_sine(f);
      q15  = (s + 16384) / 32768;
      if (q15 > 32767) begin
        q15 = 32767;
      end
      rom[i] = 16'(quad[1] ? -q15 : q15);
    end
    return rom;
  endfunction

endpackage

[rtl/multi_waveform_phase_oscillator.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid/in_tready    tdata phase_increment, tuser note_active
// out_     master     out_tvalid/out_tready  tdata sample (Q1.15)
// cfg_     slave      cfg_valid/cfg_ready    index 0 waveform, 1 keep_running_when_idle
//
// One tick per cycle sustained while out_tready stays high; a tick is written into the queue,
// then loaded into the output register, from which its sample can transfer.
// The phase add, shaping and sine table read share the same cycle in the back.
// A two-entry queue parts the input from the back, and the output register parts the
// back from the sink, so in_tready drops only when both are full.
// Reset (rst_n, synchronous) clears phase, noise state, config registers, output valid and the queue.

module multi_waveform_phase_oscillator import mwo_pkg::*; #(
  parameter int PHASE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // [30:0] phase_increment, [31] zero fill
  input  logic                 in_tuser,   // [0] note_active
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [15:0] sample
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [2:0] wave_r, wave_nxt;
  logic       keep_r, keep_nxt;
  logic       q_valid;
  logic       q_pop;
  mwo_item_t  q_item;

  // Register writes
  assign cfg_ready = 1'b1;

  always_comb begin
    wave_nxt = wave_r;
    keep_nxt = keep_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_WAVEFORM) begin
        wave_nxt = cfg_data[2:0];
      end else if (cfg_index == REG_KEEP_RUNNING) begin
        keep_nxt = cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= WAVE_PULSE;
      keep_r <= 1'b0;
    end else begin
      wave_r <= wave_nxt;
      keep_r <= keep_nxt;
    end
  end

  mwo_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .keep_run  (keep_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  mwo_back #(
    .PHASE_BITS (PHASE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .wave       (wave_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // Reset leaves no sample pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("sample pending after reset");

  // An idle tick gives a zero sample
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_item.run) |=> (out_tdata == 16'h0000))
    else $error("idle tick gave nonzero sample");

  // Silent and unused codes give a zero sample
  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (wave_r >= WAVE_SILENT))
    |=> (out_tdata == 16'h0000))
    else $error("silent waveform gave nonzero sample");

  // Pulse only takes the two extreme levels
  a_pulse_levels: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.run && wave_r == WAVE_PULSE)
    |=> (out_tdata == 16'h7FFF || out_tdata == 16'h8000))
    else $error("pulse sample off its levels");
`endif

endmodule

[rtl/mwo_front.sv]
`timescale 1ns / 1ps

module mwo_front import mwo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] phase_increment, [31] zero fill
  input  logic        in_tuser,   // [0] note_active
  input  logic        keep_run,
  output logic        q_valid,
  output mwo_item_t   q_item,
  input  logic        q_pop
);

  mwo_item_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   cnt_r, cnt_nxt;
  logic               push;
  mwo_item_t          item_in;

  // Classify the tick: runs on an active note or in keep-running mode
  always_comb begin
    item_in.inc = in_tdata[30:0];
    item_in.run = in_tuser | keep_run;
  end

  assign in_tready = (cnt_r != (Q_PTR_W+1)'(Q_DEPTH));
  assign push      = in_tvalid & in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the accepted tick
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

[rtl/mwo_back.sv]
`timescale 1ns / 1ps

module mwo_back import mwo_pkg::*; #(
  parameter int PHASE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  mwo_item_t   q_item,
  output logic        q_pop,
  input  logic [2:0]  wave,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [15:0] sample
);

  localparam int SHL = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
  localparam int SHR = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
  localparam sine_rom_t SINE_ROM = build_sine();

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] inc_al;
  logic [PHASE_BITS-1:0] phase_sum;
  logic [31:0]           lcg_r, lcg_nxt;
  logic [31:0]           lcg_step;
  logic                  out_valid_r, out_valid_nxt;
  logic [15:0]           out_data_r, out_data_nxt;
  logic [63:0]           inc64;
  logic [63:0]           phase_ext;
  logic [16:0]           top17;
  logic signed [17:0]    tri_s;
  logic [15:0]           tri_v;
  logic [15:0]           sample_c;

  // Align the step to the accumulator width and add
  assign inc64     = {33'd0, q_item.inc};
  assign inc_al    = PHASE_BITS'((inc64 << SHL) >> SHR);
  assign phase_sum = phase_r + inc_al;

  // Left-justify the phase so the top bits sit at fixed positions
  assign phase_ext = {phase_sum, {(64-PHASE_BITS){1'b0}}};
  assign top17     = phase_ext[63:47];

  // Next noise state
  assign lcg_step = lcg_r * LCG_MUL + LCG_ADD;

  // Triangle: rise over the first half, fall over the second, clip at +1
  always_comb begin
    if (top17[16]) begin
      tri_s = 18'sd98304 - $signed({1'b0, top17});
      if (tri_s > 18'sd32767) begin
        tri_s = 18'sd32767;
      end
    end else begin
      tri_s = $signed({1'b0, top17}) - 18'sd32768;
    end
    tri_v = tri_s[15:0];
  end

  // Shape the new phase (or, for noise, the next noise state) into one sample
  always_comb begin
    case (wave)
      WAVE_PULSE: sample_c = phase_ext[63] ? 16'h7FFF : 16'h8000;
      WAVE_SAW:   sample_c = {~phase_ext[63], phase_ext[62:48]};
      WAVE_TRI:   sample_c = tri_v;
      WAVE_SINE:  sample_c = SINE_ROM[phase_ext[63 -: SINE_IDX_W]];
      WAVE_NOISE: sample_c = {~lcg_step[31], lcg_step[30:16]};
      default:    sample_c = 16'h0000;
    endcase
  end

  // Take a tick when the output register is free or being drained
  assign q_pop = q_valid & (~out_valid_r | out_tready);

  always_comb begin
    phase_nxt     = phase_r;
    lcg_nxt       = lcg_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = q_item.run ? sample_c : 16'h0000;
      if (q_item.run) begin
        phase_nxt = phase_sum;
        if (wave == WAVE_NOISE) begin
          lcg_nxt = lcg_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      lcg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      lcg_r       <= lcg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the sample until transfer
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
